### rtl/core/terrain_tilt_from_leg_geometry_assert.svh
// Assertion macros shared by the terrain tilt RTL.
`ifndef TERRAIN_TILT_FROM_LEG_GEOMETRY_ASSERT_SVH
`define TERRAIN_TILT_FROM_LEG_GEOMETRY_ASSERT_SVH

// When ante holds, cons must hold in the same cycle.
`define TTLG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold.
`define TTLG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/ttlg_pkg.sv
package ttlg_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int TAB_LEN         = 24;
  localparam int CORDIC_ITERS    = (ANGLE_FRAC_BITS < TAB_LEN) ? ANGLE_FRAC_BITS : TAB_LEN;

  // angle unit inside the rotators: 0.01 degree with 16 fractional bits
  localparam int Z_FRAC = 16;
  localparam int Z_W    = 32;

  localparam int ANG_W   = 15;
  localparam int RNG_W   = 16;
  localparam int CFG_W   = 10;
  localparam int OUT_W   = 15;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int CS_W = ANGLE_FRAC_BITS + 4;   // sine / cosine datapath
  localparam int R_W  = 16;                    // radial distance of a foot
  localparam int FZ_W = 20;                    // foot height
  localparam int N_W  = 40;                    // plane normal components
  localparam int AT_W = N_W + Z_FRAC + 3;      // vectoring datapath

  localparam longint GAIN_Q30  = 652032874;
  localparam int     SIN60_Q20 = 908092;
  localparam int     DEG90     = 9000;
  localparam int     DEG180    = 18000;
  localparam int     DEG360    = 36000;

  localparam logic signed [CS_W-1:0] GAIN_INIT =
    CS_W'(GAIN_Q30 >> (30 - ANGLE_FRAC_BITS));

  localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45
  };

  typedef enum logic [1:0] {
    REG_ARM_LENGTH,
    REG_LEG_HEIGHT_OFFSET,
    REG_BASE_RADIUS,
    REG_SENSOR_OFFSET
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] arm_length;
    logic [CFG_W-1:0] leg_height_offset;
    logic [CFG_W-1:0] base_radius;
    logic [CFG_W-1:0] sensor_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [R_W-1:0]  r;
    logic signed [FZ_W-1:0] fz;
  } leg_t;

endpackage

### rtl/core/ttlg_in_if.sv
interface ttlg_in_if import ttlg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] angle_a;
  logic [ANG_W-1:0] angle_b;
  logic [ANG_W-1:0] angle_c;
  logic [RNG_W-1:0] range_a;
  logic [RNG_W-1:0] range_b;
  logic [RNG_W-1:0] range_c;

  modport source(output valid, angle_a, angle_b, angle_c, range_a, range_b, range_c,
                 input ready);
  modport sink(input valid, angle_a, angle_b, angle_c, range_a, range_b, range_c,
               output ready);
endinterface

### rtl/core/ttlg_out_if.sv
interface ttlg_out_if import ttlg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] ground_pitch;
  logic signed [OUT_W-1:0] ground_roll;
  logic                    degenerate;
  logic                    no_ground;

  modport source(output valid, ground_pitch, ground_roll, degenerate, no_ground,
                 input ready);
  modport sink(input valid, ground_pitch, ground_roll, degenerate, no_ground,
               output ready);
endinterface

### rtl/core/ttlg_leg_lane.sv
module ttlg_leg_lane import ttlg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic             tag_i,
  input  logic [ANG_W-1:0] angle_i,
  input  logic [RNG_W-1:0] range_i,
  input  cfg_t             cfg_i,
  output logic             valid_o,
  output logic             tag_o,
  output leg_t             leg_o
);

  localparam int N   = CORDIC_ITERS;
  localparam int P_W = CS_W + CFG_W + 1;

  function automatic logic signed [P_W-1:0] trunc_frac(input logic signed [P_W-1:0] v);
    return v[P_W-1] ? -((-v) >>> ANGLE_FRAC_BITS) : (v >>> ANGLE_FRAC_BITS);
  endfunction

  // angle reduction into -90..90 degrees
  logic signed [17:0] t_full, t_wrap, t_fold;
  logic               flip_c;

  always_comb begin
    t_full = $signed({3'b000, angle_i});
    t_wrap = (t_full >= 18'(DEG180)) ? t_full - 18'(DEG360) : t_full;
    flip_c = 1'b0;
    t_fold = t_wrap;
    priority if (t_wrap > 18'(DEG90)) begin
      t_fold = 18'(DEG180) - t_wrap;
      flip_c = 1'b1;
    end else if (t_wrap < -18'(DEG90)) begin
      t_fold = -18'(DEG180) - t_wrap;
      flip_c = 1'b1;
    end else begin
      t_fold = t_wrap;
    end
  end

  logic signed [CS_W-1:0] x_q [N+1];
  logic signed [CS_W-1:0] y_q [N+1];
  logic signed [Z_W-1:0]  z_q [N+1];
  logic                   flip_q [N+1];
  logic                   tag_q [N+1];
  logic [RNG_W-1:0]       rng_q [N+1];
  logic                   vld_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= GAIN_INIT;
      y_q[0]    <= '0;
      z_q[0]    <= Z_W'(t_fold) <<< Z_FRAC;
      flip_q[0] <= flip_c;
      tag_q[0]  <= tag_i;
      rng_q[0]  <= range_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CS_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end
        flip_q[i+1] <= flip_q[i];
        tag_q[i+1]  <= tag_q[i];
        rng_q[i+1]  <= rng_q[i];
      end
    end
  end

  // scale by the arm length
  logic signed [CS_W-1:0]  cos_c;
  logic signed [CFG_W:0]   arm_s;
  logic signed [P_W-1:0]   ps_q, pc_q;
  logic [RNG_W-1:0]        rng_p_q;
  logic                    tag_p_q, vld_p_q;

  assign cos_c = flip_q[N] ? -x_q[N] : x_q[N];
  assign arm_s = $signed({1'b0, cfg_i.arm_length});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      vld_p_q <= vld_q[N];
      valid_o <= vld_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ps_q    <= P_W'(arm_s) * P_W'(y_q[N]);
      pc_q    <= P_W'(arm_s) * P_W'(cos_c);
      rng_p_q <= rng_q[N];
      tag_p_q <= tag_q[N];
    end
  end

  // foot radius and height
  logic signed [P_W-1:0] reach_c, height_c;
  leg_t                  leg_d;

  always_comb begin
    reach_c  = trunc_frac(ps_q);
    height_c = trunc_frac(pc_q);
    leg_d.r  = R_W'($signed({1'b0, cfg_i.base_radius})) + R_W'(reach_c);
    leg_d.fz = FZ_W'($signed({1'b0, cfg_i.leg_height_offset})) + FZ_W'(height_c)
             + FZ_W'($signed({1'b0, rng_p_q}))
             - FZ_W'($signed({1'b0, cfg_i.sensor_offset}));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      leg_o <= leg_d;
      tag_o <= tag_p_q;
    end
  end

endmodule

### rtl/core/ttlg_atan.sv
module ttlg_atan import ttlg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic                    tag_i,
  input  logic signed [N_W-1:0]   comp_i,
  input  logic signed [N_W-1:0]   nz_i,
  output logic                    valid_o,
  output logic                    tag_o,
  output logic                    degen_o,
  output logic signed [OUT_W-1:0] angle_o
);

  localparam int N = CORDIC_ITERS;

  // fold the sign of nz into the numerator so the denominator is positive
  logic signed [N_W-1:0] num_c, den_c;
  logic signed [OUT_W-1:0] sat_c;

  always_comb begin
    num_c = nz_i[N_W-1] ? -comp_i : comp_i;
    den_c = nz_i[N_W-1] ? -nz_i : nz_i;
    if (comp_i == '0) begin
      sat_c = '0;
    end else if (comp_i[N_W-1]) begin
      sat_c = -OUT_W'(DEG90);
    end else begin
      sat_c = OUT_W'(DEG90);
    end
  end

  logic signed [AT_W-1:0]  x_q [N+1];
  logic signed [AT_W-1:0]  y_q [N+1];
  logic signed [Z_W-1:0]   z_q [N+1];
  logic signed [OUT_W-1:0] sat_q [N+1];
  logic                    dg_q [N+1];
  logic                    tag_q [N+1];
  logic                    vld_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]   <= AT_W'(den_c) <<< Z_FRAC;
      y_q[0]   <= AT_W'(num_c) <<< Z_FRAC;
      z_q[0]   <= '0;
      sat_q[0] <= sat_c;
      dg_q[0]  <= (nz_i == '0);
      tag_q[0] <= tag_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [AT_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!y_q[i][AT_W-1]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end
        sat_q[i+1] <= sat_q[i];
        dg_q[i+1]  <= dg_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  // round half up, clamp to a quarter turn; a degenerate input takes the saturated value
  logic signed [Z_W-1:0]   rnd_c;
  logic signed [OUT_W-1:0] angle_d;

  always_comb begin
    rnd_c = (z_q[N] + Z_W'(32'sd32768)) >>> Z_FRAC;
    priority if (dg_q[N]) begin
      angle_d = sat_q[N];
    end else if (rnd_c > Z_W'(DEG90)) begin
      angle_d = OUT_W'(DEG90);
    end else if (rnd_c < -Z_W'(DEG90)) begin
      angle_d = -OUT_W'(DEG90);
    end else begin
      angle_d = OUT_W'(rnd_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_o <= angle_d;
      degen_o <= dg_q[N];
      tag_o   <= tag_q[N];
    end
  end

endmodule

### rtl/core/ttlg_merge.sv
module ttlg_merge import ttlg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic                    tag_i,
  input  leg_t                    leg_a_i,
  input  leg_t                    leg_b_i,
  input  leg_t                    leg_c_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] pitch_o,
  output logic signed [OUT_W-1:0] roll_o,
  output logic                    degenerate_o,
  output logic                    no_ground_o
);

  localparam int SM_W = R_W + 21;
  localparam int C_W  = 18;
  localparam int D_W  = FZ_W + 1;
  localparam int M_W  = C_W + D_W;
  localparam logic signed [SM_W-1:0] SIN60 = SM_W'(SIN60_Q20);

  function automatic logic signed [R_W-1:0] half_trunc(input logic signed [R_W-1:0] v);
    return v[R_W-1] ? -((-v) >>> 1) : (v >>> 1);
  endfunction

  function automatic logic signed [SM_W-1:0] q20_trunc(input logic signed [SM_W-1:0] v);
    return v[SM_W-1] ? -((-v) >>> 20) : (v >>> 20);
  endfunction

  logic [3:0] vld_q, tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q <= {tag_q[2:0], tag_i};
    end
  end

  // foot positions
  logic signed [SM_W-1:0] pa_q, pb_q;
  logic signed [R_W-1:0]  ax_q, bx_q, cx_q;
  logic signed [FZ_W-1:0] az_q, bz_q, cz_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q <= SM_W'(leg_a_i.r) * SIN60;
      pb_q <= SM_W'(leg_b_i.r) * SIN60;
      ax_q <= half_trunc(leg_a_i.r);
      bx_q <= half_trunc(leg_b_i.r);
      cx_q <= -leg_c_i.r;
      az_q <= leg_a_i.fz;
      bz_q <= leg_b_i.fz;
      cz_q <= leg_c_i.fz;
    end
  end

  // edge vectors u = c - a, v = b - a
  logic signed [C_W-1:0] ay_c, by_c;
  logic signed [C_W-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [D_W-1:0] uz_q, vz_q;

  assign ay_c = -C_W'(q20_trunc(pa_q));
  assign by_c = C_W'(q20_trunc(pb_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ux_q <= C_W'(cx_q) - C_W'(ax_q);
      uy_q <= -ay_c;
      vx_q <= C_W'(bx_q) - C_W'(ax_q);
      vy_q <= by_c - ay_c;
      uz_q <= D_W'(cz_q) - D_W'(az_q);
      vz_q <= D_W'(bz_q) - D_W'(az_q);
    end
  end

  // cross product terms
  logic signed [M_W-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m0_q <= M_W'(uy_q) * M_W'(vz_q);
      m1_q <= M_W'(uz_q) * M_W'(vy_q);
      m2_q <= M_W'(uz_q) * M_W'(vx_q);
      m3_q <= M_W'(ux_q) * M_W'(vz_q);
      m4_q <= M_W'(ux_q) * M_W'(vy_q);
      m5_q <= M_W'(uy_q) * M_W'(vx_q);
    end
  end

  logic signed [N_W-1:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nx_q <= N_W'(m0_q) - N_W'(m1_q);
      ny_q <= N_W'(m2_q) - N_W'(m3_q);
      nz_q <= N_W'(m4_q) - N_W'(m5_q);
    end
  end

  ttlg_atan u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_i),
    .valid_i (vld_q[3]),
    .tag_i   (tag_q[3]),
    .comp_i  (nx_q),
    .nz_i    (nz_q),
    .valid_o (valid_o),
    .tag_o   (no_ground_o),
    .degen_o (degenerate_o),
    .angle_o (pitch_o)
  );

  ttlg_atan u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_i),
    .valid_i (vld_q[3]),
    .tag_i   (tag_q[3]),
    .comp_i  (ny_q),
    .nz_i    (nz_q),
    .valid_o (),
    .tag_o   (),
    .degen_o (),
    .angle_o (roll_o)
  );

endmodule

### rtl/core/terrain_tilt_from_leg_geometry.sv
// Each accepted transaction passes through the leg lanes and the merge stage to its result on out_ch_o.
// Throughput: one transaction per cycle while the output is not stalled; each leg has its own 16-step rotator
// pipeline and pitch and roll each have a 16-step vectoring pipeline.
// A stalled output holds the whole pipeline and drops in_ch_i.ready.
// Reset: asynchronous, active low; clears all valid bits and loads the
// registers with arm_length 120, leg_height_offset 50, others 0.
module terrain_tilt_from_leg_geometry import ttlg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ttlg_in_if.sink            in_ch_i,
  ttlg_out_if.source         out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  `include "terrain_tilt_from_leg_geometry_assert.svh"

  cfg_t cfg_q;
  cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_length        <= CFG_W'(120);
      cfg_q.leg_height_offset <= CFG_W'(50);
      cfg_q.base_radius       <= '0;
      cfg_q.sensor_offset     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_ARM_LENGTH:        cfg_q.arm_length        <= pwdata[CFG_W-1:0];
        REG_LEG_HEIGHT_OFFSET: cfg_q.leg_height_offset <= pwdata[CFG_W-1:0];
        REG_BASE_RADIUS:       cfg_q.base_radius       <= pwdata[CFG_W-1:0];
        REG_SENSOR_OFFSET:     cfg_q.sensor_offset     <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ARM_LENGTH:        prdata = PDATA_W'(cfg_q.arm_length);
      REG_LEG_HEIGHT_OFFSET: prdata = PDATA_W'(cfg_q.leg_height_offset);
      REG_BASE_RADIUS:       prdata = PDATA_W'(cfg_q.base_radius);
      REG_SENSOR_OFFSET:     prdata = PDATA_W'(cfg_q.sensor_offset);
    endcase
  end

  // advance every stage unless the result register is full and not taken
  logic adv;
  logic out_valid;
  logic no_ground_c;
  logic vld_a, vld_b, vld_c;
  logic tag_a, tag_b, tag_c;
  leg_t leg_a, leg_b, leg_c;

  assign adv             = !out_valid || out_ch_o.ready;
  assign in_ch_i.ready   = adv;
  assign out_ch_o.valid  = out_valid;
  assign no_ground_c     = (in_ch_i.range_a == '0) && (in_ch_i.range_b == '0) &&
                           (in_ch_i.range_c == '0);

  ttlg_leg_lane u_lane_a (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv), .valid_i (in_ch_i.valid),
    .tag_i (no_ground_c), .angle_i (in_ch_i.angle_a), .range_i (in_ch_i.range_a),
    .cfg_i (cfg_q), .valid_o (vld_a), .tag_o (tag_a), .leg_o (leg_a)
  );

  ttlg_leg_lane u_lane_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv), .valid_i (in_ch_i.valid),
    .tag_i (1'b0), .angle_i (in_ch_i.angle_b), .range_i (in_ch_i.range_b),
    .cfg_i (cfg_q), .valid_o (vld_b), .tag_o (tag_b), .leg_o (leg_b)
  );

  ttlg_leg_lane u_lane_c (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv), .valid_i (in_ch_i.valid),
    .tag_i (1'b0), .angle_i (in_ch_i.angle_c), .range_i (in_ch_i.range_c),
    .cfg_i (cfg_q), .valid_o (vld_c), .tag_o (tag_c), .leg_o (leg_c)
  );

  ttlg_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (vld_a),
    .tag_i        (tag_a),
    .leg_a_i      (leg_a),
    .leg_b_i      (leg_b),
    .leg_c_i      (leg_c),
    .valid_o      (out_valid),
    .pitch_o      (out_ch_o.ground_pitch),
    .roll_o       (out_ch_o.ground_roll),
    .degenerate_o (out_ch_o.degenerate),
    .no_ground_o  (out_ch_o.no_ground)
  );

  `TTLG_ASSERT_NEVER(a_lanes_aligned, clk_i, rst_ni, (vld_a != vld_b) || (vld_a != vld_c) || (vld_b && tag_b) || (vld_c && tag_c), "leg lanes out of step")
  `TTLG_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, out_valid && !out_ch_o.ready, !in_ch_i.ready, "input taken while result stalled")
  `TTLG_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, out_valid, ($signed(out_ch_o.ground_pitch) <= DEG90) && ($signed(out_ch_o.ground_pitch) >= -DEG90), "pitch out of range")
  `TTLG_ASSERT_IMP(a_degenerate_sat, clk_i, rst_ni, out_valid && out_ch_o.degenerate, ($signed(out_ch_o.ground_roll) == DEG90) || ($signed(out_ch_o.ground_roll) == -DEG90) || (out_ch_o.ground_roll == '0), "degenerate roll not saturated")

endmodule
